[rtl/bis_pkg.sv]
// Shared constants and types for the bilinear image scaler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bis_pkg;

  // Image store geometry (powers of two), fraction width and field widths
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 16;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int COORD_W = 10;
  localparam int PIX_W   = 8;
  localparam int SIZE_W  = 9;
  localparam int STEP_W  = 24;
  localparam int CFG_W   = 24;

  localparam int POS_W = COORD_W + STEP_W;
  localparam int IP_W  = POS_W - FRAC_BITS;
  localparam int WT_W  = FRAC_BITS + 1;
  localparam int H_W   = PIX_W + FRAC_BITS;
  localparam int V_W   = PIX_W + 2 * FRAC_BITS;

  // Four banks by column and row parity, each a quarter of the store
  localparam int BANK_AW    = COL_W - 1 + ROW_W - 1;
  localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / 4;

  localparam logic [WT_W-1:0] ONE_FX = WT_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_STEP_X     = 2'd2,
    REG_STEP_Y     = 2'd3
  } bis_reg_t;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_REQUEST = 1'b1
  } bis_cmd_t;

  // Per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } bis_adv_t;

  // The four neighbours of one sample point
  typedef struct packed {
    logic [PIX_W-1:0] p00;
    logic [PIX_W-1:0] p10;
    logic [PIX_W-1:0] p01;
    logic [PIX_W-1:0] p11;
  } bis_quad_t;

endpackage

[rtl/bis_locate.sv]
// Source position stages: coordinate times step, then edge clamp and split.
// Depends on bis_pkg.
`timescale 1ns / 1ps

module bis_locate import bis_pkg::*; (
  input  logic                 clk,
  input  bis_adv_t             adv,
  input  logic [COORD_W-1:0]   col,
  input  logic [COORD_W-1:0]   row,
  input  logic [STEP_W-1:0]    step_x,
  input  logic [STEP_W-1:0]    step_y,
  input  logic [SIZE_W-1:0]    src_width,
  input  logic [SIZE_W-1:0]    src_height,
  output logic [COL_W-1:0]     i0,
  output logic [ROW_W-1:0]     j0,
  output logic [FRAC_BITS-1:0] s,
  output logic [FRAC_BITS-1:0] t
);

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  logic [POS_W-1:0]     pos_x_r, pos_y_r;
  logic [COL_W-1:0]     i0_r, i0_nxt;
  logic [ROW_W-1:0]     j0_r, j0_nxt;
  logic [FRAC_BITS-1:0] s_r, s_nxt, t_r, t_nxt;
  logic [SIZE_W-1:0]    w_eff, h_eff, w_m1, h_m1;
  logic [IP_W-1:0]      ip_x, ip_y;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      pos_x_r <= POS_W'(col) * POS_W'(step_x);
      pos_y_r <= POS_W'(row) * POS_W'(step_y);
    end
  end

  always_comb begin
    w_eff = clamp_size(src_width, SIZE_W'(MAX_WIDTH));
    h_eff = clamp_size(src_height, SIZE_W'(MAX_HEIGHT));
    w_m1  = w_eff - SIZE_W'(1);
    h_m1  = h_eff - SIZE_W'(1);
    ip_x  = pos_x_r[POS_W-1:FRAC_BITS];
    ip_y  = pos_y_r[POS_W-1:FRAC_BITS];
    // saturate at the last column/row and drop the fraction
    if (ip_x >= IP_W'(w_m1)) begin
      i0_nxt = w_m1[COL_W-1:0];
      s_nxt  = '0;
    end else begin
      i0_nxt = ip_x[COL_W-1:0];
      s_nxt  = pos_x_r[FRAC_BITS-1:0];
    end
    if (ip_y >= IP_W'(h_m1)) begin
      j0_nxt = h_m1[ROW_W-1:0];
      t_nxt  = '0;
    end else begin
      j0_nxt = ip_y[ROW_W-1:0];
      t_nxt  = pos_y_r[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      i0_r <= i0_nxt;
      j0_r <= j0_nxt;
      s_r  <= s_nxt;
      t_r  <= t_nxt;
    end
  end

  assign i0 = i0_r;
  assign j0 = j0_r;
  assign s  = s_r;
  assign t  = t_r;

endmodule

[rtl/bis_store.sv]
// Image store in four parity banks so that all four pixels of a 2x2 neighbourhood are read together.
// Depends on bis_pkg.
`timescale 1ns / 1ps

module bis_store import bis_pkg::*; (
  input  logic               clk,
  input  bis_adv_t           adv,
  input  logic               wr_en,
  input  logic [COL_W-1:0]   wr_col,
  input  logic [ROW_W-1:0]   wr_row,
  input  logic [PIX_W-1:0]   wr_pixel,
  input  logic [COL_W-1:0]   i0,
  input  logic [ROW_W-1:0]   j0,
  output bis_quad_t          quad
);

  logic [COL_W-1:0] col_even, col_odd;
  logic [ROW_W-1:0] row_even, row_odd;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic [PIX_W-1:0] rd_r [4];
  logic             pi_r, pj_r;

  // Even bank holds i0 or i0+1, whichever is even; wraps only where weight is zero
  always_comb begin
    col_inc  = (COL_W+1)'(i0) + (COL_W+1)'(1);
    row_inc  = (ROW_W+1)'(j0) + (ROW_W+1)'(1);
    col_even = col_inc[COL_W:1];
    col_odd  = (COL_W)'(i0[COL_W-1:1]);
    row_even = row_inc[ROW_W:1];
    row_odd  = (ROW_W)'(j0[ROW_W-1:1]);
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0]   mem [BANK_DEPTH];
    logic [BANK_AW-1:0] rd_addr;
    logic               wr_sel;

    assign rd_addr = {(b >= 2) ? row_odd[ROW_W-2:0] : row_even[ROW_W-2:0],
                      (b % 2 == 1) ? col_odd[COL_W-2:0] : col_even[COL_W-2:0]};
    assign wr_sel  = wr_en && (wr_row[0] == 1'(b / 2)) && (wr_col[0] == 1'(b % 2));

    always_ff @(posedge clk) begin
      if (wr_sel) begin
        mem[{wr_row[ROW_W-1:1], wr_col[COL_W-1:1]}] <= wr_pixel;
      end
      if (adv.s3) begin
        rd_r[b] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      pi_r <= i0[0];
      pj_r <= j0[0];
    end
  end

  // Bank index is {row parity, column parity}
  assign quad.p00 = rd_r[{pj_r, pi_r}];
  assign quad.p10 = rd_r[{pj_r, ~pi_r}];
  assign quad.p01 = rd_r[{~pj_r, pi_r}];
  assign quad.p11 = rd_r[{~pj_r, ~pi_r}];

endmodule

[rtl/bis_blend.sv]
// Weighting stages: horizontal blend of both rows, then vertical blend and truncate.
// Depends on bis_pkg.
`timescale 1ns / 1ps

module bis_blend import bis_pkg::*; (
  input  logic                 clk,
  input  bis_adv_t             adv,
  input  bis_quad_t            quad,
  input  logic [FRAC_BITS-1:0] s,
  input  logic [FRAC_BITS-1:0] t,
  output logic [PIX_W-1:0]     pix
);

  logic [H_W-1:0]       h0_r, h0_nxt, h1_r, h1_nxt;
  logic [FRAC_BITS-1:0] t_r;
  logic [PIX_W-1:0]     p00, p10, p01, p11;
  logic [WT_W-1:0]      ws0, ws1, wt0, wt1;
  logic [V_W-1:0]       v_sum;
  logic [PIX_W-1:0]     pix_r;

  // A neighbour with zero weight may lie beyond the written image: force it to zero
  always_comb begin
    p00    = quad.p00;
    p10    = (s == '0) ? '0 : quad.p10;
    p01    = (t == '0) ? '0 : quad.p01;
    p11    = (s == '0 || t == '0) ? '0 : quad.p11;
    ws1    = WT_W'(s);
    ws0    = ONE_FX - ws1;
    h0_nxt = H_W'(H_W'(p00) * H_W'(ws0)) + H_W'(H_W'(p10) * H_W'(ws1));
    h1_nxt = H_W'(H_W'(p01) * H_W'(ws0)) + H_W'(H_W'(p11) * H_W'(ws1));
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      h0_r <= h0_nxt;
      h1_r <= h1_nxt;
      t_r  <= t;
    end
  end

  always_comb begin
    wt1   = WT_W'(t_r);
    wt0   = ONE_FX - wt1;
    v_sum = V_W'(V_W'(h0_r) * V_W'(wt0)) + V_W'(V_W'(h1_r) * V_W'(wt1));
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      pix_r <= v_sum[V_W-1:2*FRAC_BITS];
    end
  end

  assign pix = pix_r;

endmodule

[rtl/bilinear_image_scaler.sv]
// Bilinear image scaler top level: configuration, pipeline control, field pipes.
// Depends on bis_pkg, bis_locate, bis_store and bis_blend.
//
//   port group | dir  | flow control     | carries
//   in_*       | in   | in_valid/ready   | cmd, col, row, pixel
//   out_*      | out  | out_valid/ready  | interpolated pixel, col, row
//   cfg_*      | in   | cfg_we only      | register index and data
//
// Five register stages: multiply, clamp and split, banked store read,
// horizontal blend, vertical blend. One item is taken every cycle, limited
// by nothing but out_ready. Writes update the store at the read stage, so
// order is kept. Each stage holds on its own when the next is full; bubbles
// are filled. Reset clears valid bits and sets configuration to full size
// and unit step; the store stays unknown.
`timescale 1ns / 1ps

module bilinear_image_scaler import bis_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [COORD_W-1:0] in_col,
  input  logic [COORD_W-1:0] in_row,
  input  logic [PIX_W-1:0]   in_pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_pixel,
  output logic [COORD_W-1:0] out_col,
  output logic [COORD_W-1:0] out_row,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  logic [SIZE_W-1:0] src_width_r, src_height_r;
  logic [STEP_W-1:0] step_x_r, step_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SIZE_W'(MAX_WIDTH);
      src_height_r <= SIZE_W'(MAX_HEIGHT);
      step_x_r     <= STEP_W'(ONE_FX);
      step_y_r     <= STEP_W'(ONE_FX);
    end else if (cfg_we) begin
      unique case (bis_reg_t'(cfg_addr))
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata[SIZE_W-1:0];
        REG_STEP_X:     step_x_r     <= cfg_wdata[STEP_W-1:0];
        REG_STEP_Y:     step_y_r     <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage ready chain
  logic     v1_r, v2_r, v3_r, v4_r, v5_r;
  logic     rdy1, rdy2, rdy3, rdy4, rdy5;
  bis_adv_t adv;

  always_comb begin
    rdy5   = !v5_r || out_ready;
    rdy4   = !v4_r || rdy5;
    rdy3   = !v3_r || rdy4;
    rdy2   = !v2_r || rdy3;
    rdy1   = !v1_r || rdy2;
    adv.s1 = rdy1;
    adv.s2 = rdy2;
    adv.s3 = rdy3;
    adv.s4 = rdy4;
    adv.s5 = rdy5;
  end

  logic               cmd1_r, cmd2_r;
  logic [COORD_W-1:0] col1_r, col2_r, col3_r, col4_r, col5_r;
  logic [COORD_W-1:0] row1_r, row2_r, row3_r, row4_r, row5_r;
  logic [PIX_W-1:0]   pix1_r, pix2_r;
  logic               wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      // drop writes here: they leave no result
      if (rdy3) v3_r <= v2_r && (bis_cmd_t'(cmd2_r) == CMD_REQUEST);
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cmd1_r <= in_cmd;
      col1_r <= in_col;
      row1_r <= in_row;
      pix1_r <= in_pixel;
    end
    if (rdy2) begin
      cmd2_r <= cmd1_r;
      col2_r <= col1_r;
      row2_r <= row1_r;
      pix2_r <= pix1_r;
    end
    if (rdy3) begin
      col3_r <= col2_r;
      row3_r <= row2_r;
    end
    if (rdy4) begin
      col4_r <= col3_r;
      row4_r <= row3_r;
    end
    if (rdy5) begin
      col5_r <= col4_r;
      row5_r <= row4_r;
    end
  end

  // Store write at the read stage; ignore positions outside the store
  assign wr_en = rdy3 && v2_r && (bis_cmd_t'(cmd2_r) == CMD_WRITE) &&
                 (col2_r < COORD_W'(MAX_WIDTH)) && (row2_r < COORD_W'(MAX_HEIGHT));

  logic [COL_W-1:0]     i0;
  logic [ROW_W-1:0]     j0;
  logic [FRAC_BITS-1:0] s2, t2;
  logic [FRAC_BITS-1:0] s3_r, t3_r;
  bis_quad_t            quad;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_r <= s2;
      t3_r <= t2;
    end
  end

  bis_locate u_locate (
    .clk        (clk),
    .adv        (adv),
    .col        (in_col),
    .row        (in_row),
    .step_x     (step_x_r),
    .step_y     (step_y_r),
    .src_width  (src_width_r),
    .src_height (src_height_r),
    .i0         (i0),
    .j0         (j0),
    .s          (s2),
    .t          (t2)
  );

  bis_store u_store (
    .clk      (clk),
    .adv      (adv),
    .wr_en    (wr_en),
    .wr_col   (col2_r[COL_W-1:0]),
    .wr_row   (row2_r[ROW_W-1:0]),
    .wr_pixel (pix2_r),
    .i0       (i0),
    .j0       (j0),
    .quad     (quad)
  );

  bis_blend u_blend (
    .clk  (clk),
    .adv  (adv),
    .quad (quad),
    .s    (s3_r),
    .t    (t3_r),
    .pix  (out_pixel)
  );

  assign in_ready  = rdy1;
  assign out_valid = v5_r;
  assign out_col   = col5_r;
  assign out_row   = row5_r;

endmodule
